FILE: rtl/core/ssc_pkg.sv
// Shared constants, codes and types of the square suffix checker core.
// Used by every module under rtl/core except ssc_ram; depends on nothing.
`default_nettype none

package ssc_pkg;

  localparam int MAX_LEN     = 1024;
  localparam int SYMBOL_BITS = 4;
  localparam int STRIDE_W    = 11;
  localparam int ADDR_W      = $clog2(MAX_LEN);
  localparam int LEN_W       = $clog2(MAX_LEN + 1);
  localparam int DIV_W       = (LEN_W > STRIDE_W) ? LEN_W : STRIDE_W;
  localparam int POS_W       = DIV_W + 1;
  localparam int DCNT_W      = $clog2(DIV_W + 1);
  localparam int IN_TDATA_W  = ((SYMBOL_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((3 + LEN_W + 7) / 8) * 8;
  localparam int CFG_INDEX_W = 1;

  localparam logic [CFG_INDEX_W-1:0] CFG_STRIDE_P = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_STRIDE_Q = 1'b1;

  localparam logic [STRIDE_W-1:0] STRIDE_P_RST = STRIDE_W'(2);
  localparam logic [STRIDE_W-1:0] STRIDE_Q_RST = STRIDE_W'(3);

  typedef enum logic [1:0] {
    SEL_WORD,
    SEL_P,
    SEL_Q
  } sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_CHK_INIT,
    ST_HALF,
    ST_READ,
    ST_CMP,
    ST_NEXT,
    ST_DIV,
    ST_DIV_WAIT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic accept;
    logic decide_full;
    logic store;
    logic chk_start;
    logic half_init;
    logic next_half;
    logic step;
    logic set_flag;
    logic flag_val;
    logic div_start;
    logic out_load;
    sel_t sel;
  } ssc_cmd_t;

  typedef struct packed {
    logic full;
    logic half_ok;
    logic match;
    logic last_match;
    logic stride_zero;
    logic div_done;
    logic rem_zero;
    logic out_free;
  } ssc_sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/ssc_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
// Standalone; no package dependency.
`default_nettype none

module ssc_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

FILE: rtl/core/ssc_divider.sv
// Restoring divider, one quotient bit per cycle.
// Depends on ssc_pkg for DIV_W and DCNT_W.
`default_nettype none

module ssc_divider (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [ssc_pkg::DIV_W-1:0] dividend,
  input  logic [ssc_pkg::DIV_W-1:0] divisor,
  output logic                     done,
  output logic [ssc_pkg::DIV_W-1:0] quot,
  output logic [ssc_pkg::DIV_W-1:0] rem
);
  import ssc_pkg::*;

  logic [DIV_W-1:0]  rem_r, rem_nxt;
  logic [DIV_W-1:0]  quo_r, quo_nxt;
  logic [DIV_W-1:0]  dvs_r, dvs_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DIV_W:0]    shifted;
  logic [DIV_W:0]    diff;
  logic              ge;

  assign shifted = {rem_r, quo_r[DIV_W-1]};
  assign ge      = (shifted >= {1'b0, dvs_r});
  assign diff    = shifted - {1'b0, dvs_r};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = done_r;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
      cnt_nxt  = DCNT_W'(DIV_W);
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
      quo_nxt = {quo_r[DIV_W-2:0], ge};
      cnt_nxt = cnt_r - DCNT_W'(1);
      if (cnt_r == DCNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done = done_r;
  assign quot = quo_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

FILE: rtl/core/ssc_datapath.sv
// Datapath: word store, stride registers, square scan pointers, result register.
// Depends on ssc_pkg, ssc_ram and ssc_divider.
`default_nettype none

module ssc_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ssc_pkg::ssc_cmd_t             cmd,
  output ssc_pkg::ssc_sts_t             sts,
  input  logic [ssc_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic                          in_tuser,
  input  logic                          cfg_valid,
  input  logic [ssc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ssc_pkg::STRIDE_W-1:0]  cfg_data,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [ssc_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                          out_tuser
);
  import ssc_pkg::*;

  logic [LEN_W-1:0]       count_r, count_nxt;
  logic [LEN_W-1:0]       last_r, last_nxt;
  logic [SYMBOL_BITS-1:0] sym_r, sym_nxt;
  logic [STRIDE_W-1:0]    stride_p_r, stride_p_nxt;
  logic [STRIDE_W-1:0]    stride_q_r, stride_q_nxt;
  logic [DIV_W-1:0]       s_r, s_nxt;
  logic [LEN_W-1:0]       len_r, len_nxt;
  logic [LEN_W-1:0]       h_r, h_nxt;
  logic [LEN_W-1:0]       j_r, j_nxt;
  logic [POS_W-1:0]       hs_r, hs_nxt;
  logic [POS_W-1:0]       pa_r, pa_nxt;
  logic [POS_W-1:0]       pb_r, pb_nxt;
  logic                   word_free_r, word_free_nxt;
  logic                   p_free_r, p_free_nxt;
  logic                   q_free_r, q_free_nxt;
  logic                   full_r, full_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic                   out_user_r, out_user_nxt;

  logic [STRIDE_W-1:0]    sel_stride;
  logic [POS_W-1:0]       pb_base;
  logic [SYMBOL_BITS-1:0] rd_a;
  logic [SYMBOL_BITS-1:0] rd_b;
  logic                   div_done;
  logic [DIV_W-1:0]       div_quot;
  logic [DIV_W-1:0]       div_rem;

  ssc_ram #(
    .WIDTH (SYMBOL_BITS),
    .DEPTH (MAX_LEN)
  ) u_store (
    .clk     (clk),
    .we      (cmd.store),
    .waddr   (count_r[ADDR_W-1:0]),
    .wdata   (sym_r),
    .raddr_a (pa_r[ADDR_W-1:0]),
    .rdata_a (rd_a),
    .raddr_b (pb_r[ADDR_W-1:0]),
    .rdata_b (rd_b)
  );

  ssc_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (DIV_W'(last_r)),
    .divisor  (DIV_W'(sel_stride)),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  always_comb begin
    case (cmd.sel)
      SEL_Q:   sel_stride = stride_q_r;
      default: sel_stride = stride_p_r;
    endcase
  end

  assign pb_base = POS_W'(last_r) + POS_W'(s_r) - hs_r;

  always_comb begin
    sts.full        = (count_r >= LEN_W'(MAX_LEN));
    sts.half_ok     = ({h_r, 1'b0} <= {1'b0, len_r});
    sts.match       = (rd_a == rd_b);
    sts.last_match  = ((j_r + LEN_W'(1)) == h_r);
    sts.stride_zero = (sel_stride == '0);
    sts.div_done    = div_done;
    sts.rem_zero    = (div_rem == '0);
    sts.out_free    = !out_valid_r || out_tready;
  end

  always_comb begin
    count_nxt     = count_r;
    last_nxt      = last_r;
    sym_nxt       = sym_r;
    stride_p_nxt  = stride_p_r;
    stride_q_nxt  = stride_q_r;
    s_nxt         = s_r;
    len_nxt       = len_r;
    h_nxt         = h_r;
    j_nxt         = j_r;
    hs_nxt        = hs_r;
    pa_nxt        = pa_r;
    pb_nxt        = pb_r;
    word_free_nxt = word_free_r;
    p_free_nxt    = p_free_r;
    q_free_nxt    = q_free_r;
    full_nxt      = full_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;

    if (cfg_valid) begin
      case (cfg_index)
        CFG_STRIDE_P: stride_p_nxt = cfg_data;
        CFG_STRIDE_Q: stride_q_nxt = cfg_data;
        default: ;
      endcase
    end

    if (cmd.accept) begin
      sym_nxt = in_tdata[SYMBOL_BITS-1:0];
      if (in_tuser) begin
        count_nxt = '0;
      end
    end

    if (cmd.decide_full) begin
      word_free_nxt = 1'b1;
      p_free_nxt    = 1'b1;
      q_free_nxt    = 1'b1;
      full_nxt      = 1'b1;
    end

    if (cmd.store) begin
      last_nxt  = count_r;
      count_nxt = count_r + LEN_W'(1);
      full_nxt  = 1'b0;
    end

    if (cmd.chk_start) begin
      case (cmd.sel)
        SEL_WORD: begin
          s_nxt   = DIV_W'(1);
          len_nxt = count_r;
          hs_nxt  = POS_W'(1);
        end
        default: begin
          s_nxt   = DIV_W'(sel_stride);
          len_nxt = div_quot[LEN_W-1:0] + LEN_W'(1);
          hs_nxt  = POS_W'(sel_stride);
        end
      endcase
      h_nxt = LEN_W'(1);
    end

    if (cmd.half_init) begin
      pb_nxt = pb_base;
      pa_nxt = pb_base - hs_r;
      j_nxt  = '0;
    end

    if (cmd.next_half) begin
      h_nxt  = h_r + LEN_W'(1);
      hs_nxt = hs_r + POS_W'(s_r);
    end

    if (cmd.step) begin
      j_nxt  = j_r + LEN_W'(1);
      pa_nxt = pa_r + POS_W'(s_r);
      pb_nxt = pb_r + POS_W'(s_r);
    end

    if (cmd.set_flag) begin
      case (cmd.sel)
        SEL_WORD: word_free_nxt = cmd.flag_val;
        SEL_P:    p_free_nxt    = cmd.flag_val;
        SEL_Q:    q_free_nxt    = cmd.flag_val;
        default:  ;
      endcase
    end

    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = OUT_TDATA_W'({count_r, q_free_r, p_free_r, word_free_r});
      out_user_nxt  = full_r;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      stride_p_r  <= STRIDE_P_RST;
      stride_q_r  <= STRIDE_Q_RST;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      stride_p_r  <= stride_p_nxt;
      stride_q_r  <= stride_q_nxt;
      out_valid_r <= out_valid_nxt;
    end
    last_r      <= last_nxt;
    sym_r       <= sym_nxt;
    s_r         <= s_nxt;
    len_r       <= len_nxt;
    h_r         <= h_nxt;
    j_r         <= j_nxt;
    hs_r        <= hs_nxt;
    pa_r        <= pa_nxt;
    pb_r        <= pb_nxt;
    word_free_r <= word_free_nxt;
    p_free_r    <= p_free_nxt;
    q_free_r    <= q_free_nxt;
    full_r      <= full_nxt;
    out_data_r  <= out_data_nxt;
    out_user_r  <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

`default_nettype wire

FILE: rtl/core/ssc_ctrl.sv
// Controller: sequences append, square scans and stride divisions per request.
// Depends on ssc_pkg for state, select and command/status types.
`default_nettype none

module ssc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  ssc_pkg::ssc_sts_t sts,
  output ssc_pkg::ssc_cmd_t cmd
);
  import ssc_pkg::*;

  state_t state_r, state_nxt;
  sel_t   phase_r, phase_nxt;

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (sts.full) begin
          state_nxt = ST_FINISH;
        end else begin
          phase_nxt = SEL_WORD;
          state_nxt = ST_CHK_INIT;
        end
      end
      ST_CHK_INIT: state_nxt = ST_HALF;
      ST_HALF:     state_nxt = sts.half_ok ? ST_READ : ST_NEXT;
      ST_READ:     state_nxt = ST_CMP;
      ST_CMP: begin
        if (!sts.match) begin
          state_nxt = ST_HALF;
        end else if (sts.last_match) begin
          state_nxt = ST_NEXT;
        end else begin
          state_nxt = ST_READ;
        end
      end
      ST_NEXT: begin
        case (phase_r)
          SEL_WORD: begin
            phase_nxt = SEL_P;
            state_nxt = ST_DIV;
          end
          SEL_P: begin
            phase_nxt = SEL_Q;
            state_nxt = ST_DIV;
          end
          default: state_nxt = ST_FINISH;
        endcase
      end
      ST_DIV:      state_nxt = sts.stride_zero ? ST_NEXT : ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (sts.div_done) begin
          state_nxt = sts.rem_zero ? ST_CHK_INIT : ST_NEXT;
        end
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.sel   = phase_r;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
      end
      ST_DECIDE: begin
        cmd.decide_full = sts.full;
        cmd.store       = !sts.full;
      end
      ST_CHK_INIT: cmd.chk_start = 1'b1;
      ST_HALF: begin
        cmd.half_init = sts.half_ok;
        cmd.set_flag  = !sts.half_ok;
        cmd.flag_val  = 1'b1;
      end
      ST_CMP: begin
        cmd.next_half = !sts.match;
        cmd.set_flag  = sts.match && sts.last_match;
        cmd.flag_val  = 1'b0;
        cmd.step      = sts.match && !sts.last_match;
      end
      ST_DIV: begin
        cmd.set_flag  = sts.stride_zero;
        cmd.flag_val  = 1'b1;
        cmd.div_start = !sts.stride_zero;
      end
      ST_DIV_WAIT: begin
        cmd.set_flag = sts.div_done && !sts.rem_zero;
        cmd.flag_val = 1'b1;
      end
      ST_FINISH: cmd.out_load = sts.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= SEL_WORD;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/square_suffix_checker_core.sv
// Top level of the square suffix checker: controller plus datapath.
// Depends on ssc_pkg, ssc_ctrl and ssc_datapath (with ssc_ram, ssc_divider).
//
//   Group   Dir   Payload
//   in_     sink  tdata[3:0] symbol; tuser restart
//   out_    src   tdata[0] word_free, [1] stride_p_free, [2] stride_q_free,
//                 [13:3] word_length; tuser store_full
//   cfg_    sink  index 0 stride_p, 1 stride_q; data 11 bits
//
// One request at a time. Each request is accepted and appended, then each check over n
// letters tries halves from the shortest up, comparing one letter pair at a time through
// the two read ports of the word store (READ, then CMP) and moving to the next half on a
// mismatch. A stride check first runs the shared bit-serial divider.
// Reset empties the word and loads strides 2 and 3; no clearing pass. A finished result
// waits in the output register while the next request is taken; a second one stalls.
`default_nettype none

module square_suffix_checker_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [ssc_pkg::IN_TDATA_W-1:0]  in_tdata,   // [3:0] symbol
  input  logic                            in_tuser,   // [0] restart
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [ssc_pkg::OUT_TDATA_W-1:0] out_tdata,  // word_free, stride_p_free,
                                                      // stride_q_free, word_length
  output logic                            out_tuser,  // [0] store_full
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ssc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ssc_pkg::STRIDE_W-1:0]    cfg_data
);
  import ssc_pkg::*;

  ssc_cmd_t cmd;
  ssc_sts_t sts;

  assign cfg_ready = 1'b1;

  ssc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ssc_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

FILE: tb/sv/tb_square_suffix_checker_core.sv
// Self-checking bench for square_suffix_checker_core: directed table, full-store fill,
// then random square-free-leaning words under several stride settings and random stalls.
// Depends on ssc_pkg and the RTL under rtl/core; needs no files or arguments.
`default_nettype none

module tb_square_suffix_checker_core;
  import ssc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1500000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned TAIL_CYCLES = 50;

  typedef struct packed {
    logic             word_free;
    logic             p_free;
    logic             q_free;
    logic             full;
    logic [LEN_W-1:0] len;
  } verdict_t;

  typedef struct packed {
    logic [SYMBOL_BITS-1:0] sym;
    logic                   restart;
    logic                   typed;
    verdict_t               want;
  } dir_row_t;

  localparam int NDIR = 23;
  localparam verdict_t NO_WANT = '0;
  localparam dir_row_t DIR_ROWS [NDIR] = '{
    '{4'h0, 1'b0, 1'b1, '{1'b1, 1'b1, 1'b1, 1'b0, LEN_W'(1)}},
    '{4'h0, 1'b0, 1'b1, '{1'b0, 1'b1, 1'b1, 1'b0, LEN_W'(2)}},
    '{4'h0, 1'b0, 1'b0, NO_WANT},
    '{4'hF, 1'b1, 1'b1, '{1'b1, 1'b1, 1'b1, 1'b0, LEN_W'(1)}},
    '{4'hF, 1'b0, 1'b1, '{1'b0, 1'b1, 1'b1, 1'b0, LEN_W'(2)}},
    '{4'h1, 1'b1, 1'b0, NO_WANT},
    '{4'h2, 1'b0, 1'b0, NO_WANT},
    '{4'h3, 1'b0, 1'b0, NO_WANT},
    '{4'h1, 1'b0, 1'b0, NO_WANT},
    '{4'h2, 1'b0, 1'b0, NO_WANT},
    '{4'h3, 1'b0, 1'b0, NO_WANT},
    '{4'h5, 1'b0, 1'b0, NO_WANT},
    '{4'hA, 1'b0, 1'b0, NO_WANT},
    '{4'h5, 1'b0, 1'b0, NO_WANT},
    '{4'hA, 1'b0, 1'b0, NO_WANT},
    '{4'h0, 1'b1, 1'b0, NO_WANT},
    '{4'h1, 1'b0, 1'b0, NO_WANT},
    '{4'h0, 1'b0, 1'b0, NO_WANT},
    '{4'h2, 1'b0, 1'b0, NO_WANT},
    '{4'h0, 1'b0, 1'b0, NO_WANT},
    '{4'h1, 1'b0, 1'b0, NO_WANT},
    '{4'h0, 1'b0, 1'b0, NO_WANT},
    '{4'hC, 1'b0, 1'b0, NO_WANT}
  };

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   in_tuser   = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index  = CFG_STRIDE_P;
  logic [STRIDE_W-1:0]    cfg_data   = '0;

  // predicted block state
  logic [SYMBOL_BITS-1:0] word_mem [MAX_LEN];
  int unsigned            word_len     = 0;
  logic [STRIDE_W-1:0]    stride_p_cfg = STRIDE_P_RST;
  logic [STRIDE_W-1:0]    stride_q_cfg = STRIDE_Q_RST;

  verdict_t    expected_q [$];
  int unsigned err_count    = 0;
  int unsigned n_requests   = 0;
  int unsigned n_results    = 0;
  int unsigned n_settings   = 0;
  int unsigned longest_word = 0;
  int unsigned cycle_count  = 0;
  int unsigned ready_stall  = 0;
  logic        burst_mode   = 1'b0;
  logic        hold_go      = 1'b0;
  logic        hold_active  = 1'b0;

  square_suffix_checker_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [SYMBOL_BITS-1:0] sub_letter(int unsigned step, int unsigned t);
    int unsigned pos;
    pos = t * step;
    if (pos >= MAX_LEN) return '0;
    return word_mem[pos];
  endfunction

  function automatic logic no_square_tail(int unsigned step, int unsigned n);
    int unsigned half, j;
    logic        same;
    for (half = 1; 2 * half <= n; half++) begin
      same = 1'b1;
      for (j = 0; j < half && same; j++)
        if (sub_letter(step, n - 2 * half + j) != sub_letter(step, n - half + j)) same = 1'b0;
      if (same) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic stride_free(logic [STRIDE_W-1:0] s, int unsigned last);
    if (s == 0 || (last % s) != 0) return 1'b1;
    return no_square_tail(s, last / s + 1);
  endfunction

  function automatic verdict_t predict_append(logic [SYMBOL_BITS-1:0] sym, logic restart);
    verdict_t v;
    if (restart) word_len = 0;
    if (word_len >= MAX_LEN) begin
      v = '{1'b1, 1'b1, 1'b1, 1'b1, LEN_W'(word_len)};
      return v;
    end
    word_mem[word_len] = sym;
    word_len++;
    if (word_len > longest_word) longest_word = word_len;
    v.word_free = no_square_tail(1, word_len);
    v.p_free    = stride_free(stride_p_cfg, word_len - 1);
    v.q_free    = stride_free(stride_q_cfg, word_len - 1);
    v.full      = 1'b0;
    v.len       = LEN_W'(word_len);
    return v;
  endfunction

  // pick the first letter, from a random start, that keeps the word free of square suffixes
  function automatic logic [SYMBOL_BITS-1:0] extend_letter(logic [SYMBOL_BITS-1:0] a,
                                                           logic [SYMBOL_BITS-1:0] b,
                                                           logic [SYMBOL_BITS-1:0] c);
    logic [SYMBOL_BITS-1:0] cand [3];
    int unsigned            k, start;
    cand  = '{a, b, c};
    start = $urandom_range(0, 2);
    if (word_len >= MAX_LEN) return cand[start];
    for (k = 0; k < 3; k++) begin
      word_mem[word_len] = cand[(start + k) % 3];
      if (no_square_tail(1, word_len + 1)) return cand[(start + k) % 3];
    end
    return cand[start];
  endfunction

  function automatic int unsigned idle_len();
    int unsigned r;
    if (burst_mode) return 0;
    r = $urandom_range(0, 19);
    if (r < 13) return 0;
    if (r < 19) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    err_count++;
    $display("mismatch on result %0d, %s: got %0d, expected %0d", n_results, what, got, want);
  endtask

  task automatic check_result(input verdict_t got);
    verdict_t want;
    n_results++;
    if (expected_q.size() == 0) begin
      report_mismatch("result with nothing pending, word_length", 32'(got.len), 0);
      return;
    end
    want = expected_q.pop_front();
    if (got.word_free !== want.word_free)
      report_mismatch("word_free", 32'(got.word_free), 32'(want.word_free));
    if (got.p_free !== want.p_free)
      report_mismatch("stride_p_free", 32'(got.p_free), 32'(want.p_free));
    if (got.q_free !== want.q_free)
      report_mismatch("stride_q_free", 32'(got.q_free), 32'(want.q_free));
    if (got.full !== want.full)
      report_mismatch("store_full", 32'(got.full), 32'(want.full));
    if (got.len !== want.len)
      report_mismatch("word_length", 32'(got.len), 32'(want.len));
  endtask

  task automatic push_request(input logic [SYMBOL_BITS-1:0] sym, input logic restart,
                              input logic typed, input verdict_t want);
    verdict_t    v;
    int unsigned gap;
    v = predict_append(sym, restart);
    if (typed) v = want;
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TDATA_W'(sym);
    in_tuser  <= restart;
    do @(posedge clk); while (!in_tready);
    expected_q.push_back(v);
    n_requests++;
    gap = idle_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_strides(input logic [STRIDE_W-1:0] p, input logic [STRIDE_W-1:0] q);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_STRIDE_P;
    cfg_data  <= p;
    do @(posedge clk); while (!cfg_ready);
    stride_p_cfg = p;
    cfg_index <= CFG_STRIDE_Q;
    cfg_data  <= q;
    do @(posedge clk); while (!cfg_ready);
    stride_q_cfg = q;
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  task automatic run_random(input int unsigned n_items);
    logic [SYMBOL_BITS-1:0] letters [3];
    logic [SYMBOL_BITS-1:0] sym;
    logic                   restart;
    int unsigned            target;
    letters[0] = SYMBOL_BITS'($urandom_range(0, 15));
    do letters[1] = SYMBOL_BITS'($urandom_range(0, 15)); while (letters[1] == letters[0]);
    do letters[2] = SYMBOL_BITS'($urandom_range(0, 15));
    while (letters[2] == letters[0] || letters[2] == letters[1]);
    target = $urandom_range(4, 40);
    repeat (n_items) begin
      restart = (word_len >= target) || ($urandom_range(0, 11) == 0);
      if (restart) target = $urandom_range(2, 40);
      if ($urandom_range(0, 3) == 0) sym = SYMBOL_BITS'($urandom_range(0, 15));
      else if (restart) sym = letters[$urandom_range(0, 2)];
      else sym = extend_letter(letters[0], letters[1], letters[2]);
      push_request(sym, restart, 1'b0, NO_WANT);
    end
  endtask

  always @(posedge clk) begin : result_sink
    int unsigned n;
    if (rst_n && out_tvalid && out_tready)
      check_result(verdict_t'{out_tdata[0], out_tdata[1], out_tdata[2], out_tuser,
                              out_tdata[3 +: LEN_W]});
    if (hold_active) begin
      out_tready <= 1'b0;
    end else if (burst_mode) begin
      out_tready <= 1'b1;
    end else if (ready_stall > 0) begin
      ready_stall <= ready_stall - 1;
      out_tready  <= 1'b0;
    end else begin
      n = idle_len();
      out_tready  <= (n == 0);
      ready_stall <= (n > 0) ? n - 1 : 0;
    end
  end

  // hold the receiver off long enough for the block to back up and stall its input
  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_active <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_active <= 1'b0;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results pending", cycle_count, expected_q.size());
    $display("[square_suffix_checker_core] ERROR");
    $finish;
  end

  initial begin
    logic [SYMBOL_BITS-1:0] fill_sym;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NDIR; i++)
      push_request(DIR_ROWS[i].sym, DIR_ROWS[i].restart, DIR_ROWS[i].typed, DIR_ROWS[i].want);
    wait_drained();

    // fill the store with one letter so every check over two or more letters ends on its first half
    write_strides(STRIDE_W'(1), STRIDE_W'(1024));
    burst_mode <= 1'b1;
    fill_sym = SYMBOL_BITS'($urandom_range(0, 15));
    push_request(fill_sym, 1'b1, 1'b0, NO_WANT);
    repeat (MAX_LEN - 1) push_request(fill_sym, 1'b0, 1'b0, NO_WANT);
    push_request(4'h0, 1'b0, 1'b1, '{1'b1, 1'b1, 1'b1, 1'b1, LEN_W'(MAX_LEN)});
    push_request(4'hF, 1'b0, 1'b1, '{1'b1, 1'b1, 1'b1, 1'b1, LEN_W'(MAX_LEN)});
    push_request(4'h9, 1'b1, 1'b1, '{1'b1, 1'b1, 1'b1, 1'b0, LEN_W'(1)});
    wait_drained();
    burst_mode <= 1'b0;

    write_strides(STRIDE_W'(0), STRIDE_W'(2047));
    hold_go <= 1'b1;
    run_random(25);
    wait_drained();

    write_strides(STRIDE_W'(1), STRIDE_W'(2));
    run_random(25);
    wait_drained();

    write_strides(STRIDE_W'($urandom_range(1, 12)), STRIDE_W'($urandom_range(1, 12)));
    run_random(25);
    wait_drained();

    write_strides(STRIDE_W'(1024), STRIDE_W'($urandom_range(3, 7)));
    run_random(25);
    wait_drained();

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("%0d requests, %0d results checked under %0d stride settings in %0d cycles;",
             n_requests, n_results, n_settings, cycle_count);
    $display("longest word %0d letters, with dropped symbols on a full store and restart.",
             longest_word);
    if (err_count == 0 && expected_q.size() == 0) begin
      $display("[square_suffix_checker_core] OK");
    end else begin
      $display("[square_suffix_checker_core] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
rtl/core/ssc_pkg.sv
rtl/core/ssc_ram.sv
rtl/core/ssc_divider.sv
rtl/core/ssc_datapath.sv
rtl/core/ssc_ctrl.sv
rtl/core/square_suffix_checker_core.sv
tb/sv/tb_square_suffix_checker_core.sv
